/* rtl/core/lidar_packet_deframer_top_macros.svh */
// Assertion macros of the lidar packet deframer top level
`ifndef LIDAR_PACKET_DEFRAMER_TOP_MACROS_SVH
`define LIDAR_PACKET_DEFRAMER_TOP_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted
`define LDF_ASSERT_IMPLY(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// Next-cycle implication, disabled while reset is asserted
`define LDF_ASSERT_NEXT(name, clk, rst_n, ante, cons) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

/* rtl/core/ldf_pkg.sv */
// Package: types and constants of the lidar packet deframer
`timescale 1ns / 1ps

package ldf_pkg;

    localparam logic [7:0] START_BYTE  = 8'hFA;
    localparam int         READINGS    = 4;
    localparam int         FRAME_BYTES = 19;   // payload bytes that carry data
    localparam int         SCAN_POINTS = 360;
    localparam int         ANGLE_W     = 10;
    localparam int         OUT_TDATA_W = 48;

    // Decoded packet handed from the collector to the emitter
    typedef struct packed {
        logic [7:0]                 index;
        logic [READINGS-1:0][15:0]  distance;
        logic [READINGS-1:0][15:0]  strength;
    } frame_t;

    // One reading as it leaves the block
    typedef struct packed {
        logic [ANGLE_W-1:0] angle;
        logic               in_range;
        logic [15:0]        distance_mm;
        logic [15:0]        signal_strength;
        logic               scan_start;
        logic               last;
    } reading_t;

endpackage

/* rtl/core/ldf_collect.sv */
// Start-byte hunt and payload capture of the lidar packet deframer
`timescale 1ns / 1ps

module ldf_collect #(
    parameter int PAYLOAD_BYTES = 21
) (
    input  logic           aclk,
    input  logic           aresetn,
    input  logic           s_tvalid,
    output logic           s_tready,
    input  logic [7:0]     s_tdata,
    output logic           frame_valid,
    input  logic           frame_ready,
    output ldf_pkg::frame_t frame
);
    import ldf_pkg::*;

    localparam int CNT_W   = $clog2(PAYLOAD_BYTES);
    localparam int DEPTH   = PAYLOAD_BYTES - 1;
    localparam int IDX_W   = $clog2(DEPTH);
    localparam logic [CNT_W-1:0] LAST_CNT = CNT_W'(PAYLOAD_BYTES - 1);

    logic             collecting_reg, collecting_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [7:0]       store_reg [DEPTH];
    logic             accept;
    logic             final_byte;
    logic [7:0]       pkt [FRAME_BYTES];

    // final payload byte is only taken when the emitter can hold the frame
    assign final_byte  = collecting_reg && (count_reg == LAST_CNT);
    assign s_tready    = !final_byte || frame_ready;
    assign accept      = s_tvalid && s_tready;
    assign frame_valid = accept && final_byte;

    // hunt / collect sequencing
    always_comb begin
        collecting_next = collecting_reg;
        count_next      = count_reg;
        if (accept) begin
            if (!collecting_reg) begin
                if (s_tdata == START_BYTE) begin
                    collecting_next = 1'b1;
                    count_next      = '0;
                end
            end else if (final_byte) begin
                collecting_next = 1'b0;
                count_next      = '0;
            end else begin
                count_next = count_reg + 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            collecting_reg <= 1'b0;
            count_reg      <= '0;
        end else begin
            collecting_reg <= collecting_next;
            count_reg      <= count_next;
        end
    end

    // payload store, one byte per transaction
    always_ff @(posedge aclk) begin
        if (accept && collecting_reg && !final_byte) begin
            store_reg[count_reg[IDX_W-1:0]] <= s_tdata;
        end
    end

    // packet view: the final payload byte, if it falls inside the view, comes straight from the input
    for (genvar i = 0; i < FRAME_BYTES; i++) begin : g_pkt
        if (i == PAYLOAD_BYTES - 1) begin : g_live
            assign pkt[i] = s_tdata;
        end else begin : g_stored
            assign pkt[i] = store_reg[i];
        end
    end

    assign frame.index = pkt[0];
    for (genvar k = 0; k < READINGS; k++) begin : g_fields
        assign frame.distance[k] = {pkt[4 + 4*k], pkt[3 + 4*k]};
        assign frame.strength[k] = {pkt[6 + 4*k], pkt[5 + 4*k]};
    end

endmodule

/* rtl/core/ldf_emit.sv */
// Frame holding register and per-reading output register
`timescale 1ns / 1ps

module ldf_emit (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            frame_valid,
    output logic            frame_ready,
    input  ldf_pkg::frame_t frame,
    output logic            m_tvalid,
    input  logic            m_tready,
    output ldf_pkg::reading_t m_reading
);
    import ldf_pkg::*;

    frame_t    frame_reg;
    logic      pend_reg, pend_next;
    logic [1:0] rd_reg, rd_next;
    logic      out_valid_reg, out_valid_next;
    reading_t  out_reg;
    reading_t  rd_sel;
    logic      load;

    assign frame_ready = !pend_reg;
    assign load        = pend_reg && (!out_valid_reg || m_tready);

    // build the selected reading
    always_comb begin
        rd_sel.angle           = {frame_reg.index, rd_reg};
        rd_sel.in_range        = ({frame_reg.index, rd_reg} < ANGLE_W'(SCAN_POINTS));
        rd_sel.distance_mm     = frame_reg.distance[rd_reg];
        rd_sel.signal_strength = frame_reg.strength[rd_reg];
        rd_sel.scan_start      = (frame_reg.index == 8'd0);
        rd_sel.last            = (rd_reg == 2'(READINGS - 1));
    end

    // reading sequencing
    always_comb begin
        pend_next      = pend_reg;
        rd_next        = rd_reg;
        out_valid_next = out_valid_reg;
        if (m_tready) begin
            out_valid_next = 1'b0;
        end
        if (load) begin
            out_valid_next = 1'b1;
            rd_next        = rd_reg + 1'b1;
            if (rd_sel.last) begin
                pend_next = 1'b0;
            end
        end
        if (frame_valid && frame_ready) begin
            pend_next = 1'b1;
            rd_next   = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pend_reg      <= 1'b0;
            rd_reg        <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            pend_reg      <= pend_next;
            rd_reg        <= rd_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge aclk) begin
        if (frame_valid && frame_ready) begin
            frame_reg <= frame;
        end
        if (load) begin
            out_reg <= rd_sel;
        end
    end

    assign m_tvalid  = out_valid_reg;
    assign m_reading = out_reg;

endmodule

/* rtl/core/lidar_packet_deframer_top.sv */
// Top level of the lidar packet deframer
`timescale 1ns / 1ps
// Usage:
// - s_ channel: one received serial byte per transaction in s_tdata. Bytes are
//   dropped until the start byte 0xFA; the next PAYLOAD_BYTES bytes form a
//   packet, a 0xFA among them being plain data.
// - m_ channel: four readings per packet, tlast on the fourth. Each reading
//   carries angle (index * 4 + reading), in-range flag, distance, signal
//   strength and a scan-start flag (index byte zero).
// - Order: the frame holding register takes the packet with the final payload
//   byte, then the output register takes the first reading; the rest
//   follow one per cycle while m_tready is high.
// - Throughput: one byte per cycle on input while s_tready is high, one
//   reading per cycle on output while m_tready is high. A packet is the start
//   byte plus PAYLOAD_BYTES bytes; the emitter holds a single frame at a time.
// - Stall: while the receiver stalls, bytes keep being accepted; only the
//   final byte of the next packet waits (s_tready low) until all four
//   readings of the held packet have gone to the output register.
// - Reset (aresetn low, synchronous): returns to hunting, drops any held
//   packet and clears m_tvalid.
module lidar_packet_deframer_top #(
    parameter int PAYLOAD_BYTES = 21
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] rx_byte
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [ldf_pkg::OUT_TDATA_W-1:0] m_tdata,
    // [9:0] angle, [10] in_range, [26:11] distance_mm,
    // [42:27] signal_strength, [43] scan_start, [47:44] zero
    output logic        m_tlast
);
    import ldf_pkg::*;

    `include "lidar_packet_deframer_top_macros.svh"

    logic     frame_valid;
    logic     frame_ready;
    frame_t   frame;
    reading_t reading;

    ldf_collect #(
        .PAYLOAD_BYTES(PAYLOAD_BYTES)
    ) u_collect (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .frame_valid(frame_valid),
        .frame_ready(frame_ready),
        .frame      (frame)
    );

    ldf_emit u_emit (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .frame_valid(frame_valid),
        .frame_ready(frame_ready),
        .frame      (frame),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_reading  (reading)
    );

    // pack the output transaction
    assign m_tdata = {4'd0, reading.scan_start, reading.signal_strength,
                      reading.distance_mm, reading.in_range, reading.angle};
    assign m_tlast = reading.last;

    // tlast marks exactly the fourth reading of a packet
    `LDF_ASSERT_IMPLY(a_last_pos, aclk, aresetn, m_tvalid,
        (m_tlast == (m_tdata[1:0] == 2'b11)))
    // in-range flag agrees with the angle
    `LDF_ASSERT_IMPLY(a_range, aclk, aresetn, m_tvalid,
        (m_tdata[10] == (m_tdata[9:0] < ANGLE_W'(SCAN_POINTS))))
    // readings of one packet leave without gaps
    `LDF_ASSERT_NEXT(a_no_gap, aclk, aresetn, m_tvalid && m_tready && !m_tlast,
        m_tvalid)

endmodule
